// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL module of the gain mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: hdl/sgm_pkg.sv
// Package with widths, codes and sample helpers of the saturating gain mixer.
`default_nettype none
package sgm_pkg;
	localparam int DATA_W         = 32;
	localparam int POS_W          = 10;
	localparam int EXT_W          = 11;
	localparam int SUM_W          = POS_W + 1;
	localparam int GAIN_W         = 11;
	localparam int GAIN_SHIFT     = 10;
	localparam int FMT_W          = 2;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 11;
	localparam int RING_DEPTH_DEF = 1024;
	localparam int PROD_W         = DATA_W + GAIN_W + 1;
	localparam int SCALED_W       = DATA_W + 1;
	localparam int ACC_W          = DATA_W + 2;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_SHIFT);

	localparam logic [FMT_W-1:0] FMT_S16 = 2'd0;
	localparam logic [FMT_W-1:0] FMT_S24 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;

	localparam logic ACT_MIX  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	function automatic logic signed [DATA_W-1:0] sext_fmt(logic [DATA_W-1:0] x,
		logic [FMT_W-1:0] fmt);
		logic signed [DATA_W-1:0] r;
		case (fmt)
			FMT_S16: r = {{16{x[15]}}, x[15:0]};
			FMT_S24: r = {{8{x[23]}}, x[23:0]};
			default: r = x;
		endcase
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] sat_fmt(logic signed [ACC_W-1:0] v,
		logic [FMT_W-1:0] fmt);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic signed [ACC_W-1:0] r;
		case (fmt)
			FMT_S16: begin
				hi = ACC_W'(32767);
				lo = -ACC_W'(32768);
			end
			FMT_S24: begin
				hi = ACC_W'(8388607);
				lo = -ACC_W'(8388608);
			end
			default: begin
				hi = ACC_W'(64'sd2147483647);
				lo = -ACC_W'(64'sd2147483648);
			end
		endcase
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[DATA_W-1:0];
	endfunction
endpackage
`default_nettype wire

// File: hdl/sgm_ring.sv
// Sample ring memory with one write port and one registered read port.
`default_nettype none
module sgm_ring
	import sgm_pkg::*;
#(
	parameter int DEPTH = RING_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_idx,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_idx,
	output logic      [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

// File: hdl/saturating_gain_mixer.sv
// Top level of the saturating gain mixer: four-stage pipeline around the sample ring.
// A request passes stages s1, s2 and s3 to stage s4, whose valid bit is res_valid.
// Throughput: one request per cycle; a stalled result holds every stage.
// The ring is read one stage ahead of its write; a same-slot write is bypassed.
// Reset clears all valid bits, sets the format to s32 and the gain to unity.
// Ring contents are undefined after reset and need no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module saturating_gain_mixer
	import sgm_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    mix_valid,
	output logic                         mix_stall,
	input  wire logic                    action,
	input  wire logic [POS_W-1:0]        ring_base,
	input  wire logic [POS_W-1:0]        offset,
	input  wire logic [EXT_W-1:0]        mixed_extent,
	input  wire logic signed [DATA_W-1:0] sample,
	output logic                         res_valid,
	input  wire logic                    res_stall,
	output logic signed [DATA_W-1:0]     stored_value,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);
	localparam int AW        = $clog2(RING_DEPTH);
	localparam int MOD_STEPS = $clog2(((1 << SUM_W) - 1) / RING_DEPTH + 1);

	logic [FMT_W-1:0]  fmt_q;
	logic [GAIN_W-1:0] gain_q;

	logic adv;

	logic                      v_s1, act_s1, upd_s1;
	logic [SUM_W-1:0]          sum_s1;
	logic signed [DATA_W-1:0]  src_s1;

	logic                      v_s2, act_s2, upd_s2;
	logic [AW-1:0]             idx_s2;
	logic signed [PROD_W-1:0]  prod_s2;

	logic                      v_s3, act_s3, upd_s3, fwd_s3;
	logic [AW-1:0]             idx_s3;
	logic signed [SCALED_W-1:0] scaled_s3;
	logic [DATA_W-1:0]         fwd_data_s3;

	logic                      v_s4;
	logic [DATA_W-1:0]         value_s4;

	logic [SUM_W-1:0]          rem;
	logic [AW-1:0]             idx_next;
	logic signed [PROD_W-1:0]  prod_next;
	logic signed [PROD_W-1:0]  round_tmp;
	logic [DATA_W-1:0]         ring_rd;
	logic [DATA_W-1:0]         old_s3;
	logic signed [ACC_W-1:0]   acc_s3;
	logic [DATA_W-1:0]         result_s3;
	logic                      wr_en;

	// The whole pipeline moves when the result register is free or being taken.
	assign adv       = !v_s4 || !res_stall;
	assign mix_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FMT_S32;
			gain_q <= UNITY_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FORMAT: fmt_q <= cfg_data[FMT_W-1:0];
				CFG_GAIN:   gain_q <= (cfg_data > UNITY_GAIN) ? UNITY_GAIN : cfg_data;
				default:    fmt_q <= fmt_q;
			endcase
		end
	end

	always_comb begin
		rem = sum_s1;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (32'(rem) >= (32'(RING_DEPTH) << k)) begin
				rem = SUM_W'(32'(rem) - (32'(RING_DEPTH) << k));
			end
		end
		idx_next  = AW'(rem);
		prod_next = PROD_W'(src_s1) * PROD_W'($signed({1'b0, gain_q}));
		round_tmp = (prod_s2 >>> (GAIN_SHIFT - 1)) + PROD_W'(1);
	end

	assign wr_en = adv && v_s3 && (act_s3 == ACT_MIX);

	sgm_ring #(
		.DEPTH (RING_DEPTH),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (idx_s3),
		.wr_data (result_s3),
		.rd_en   (adv),
		.rd_idx  (idx_s2),
		.rd_data (ring_rd)
	);

	always_comb begin
		old_s3 = fwd_s3 ? fwd_data_s3 : ring_rd;
		if (upd_s3) begin
			acc_s3 = ACC_W'(sext_fmt(old_s3, fmt_q)) + ACC_W'(scaled_s3);
		end else begin
			acc_s3 = ACC_W'(scaled_s3);
		end
		if (act_s3 == ACT_READ) begin
			result_s3 = old_s3;
		end else begin
			result_s3 = sat_fmt(acc_s3, fmt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			fwd_s3 <= 1'b0;
		end else if (adv) begin
			v_s1   <= mix_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			fwd_s3 <= wr_en && (idx_s3 == idx_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1      <= action;
			upd_s1      <= {1'b0, offset} < mixed_extent;
			sum_s1      <= {1'b0, ring_base} + {1'b0, offset};
			src_s1      <= sext_fmt(sample, fmt_q);
			act_s2      <= act_s1;
			upd_s2      <= upd_s1;
			idx_s2      <= idx_next;
			prod_s2     <= prod_next;
			act_s3      <= act_s2;
			upd_s3      <= upd_s2;
			idx_s3      <= idx_s2;
			scaled_s3   <= SCALED_W'(round_tmp >>> 1);
			fwd_data_s3 <= result_s3;
			value_s4    <= result_s3;
		end
	end

	assign res_valid    = v_s4;
	assign stored_value = value_s4;

	`ASSERT_PROP(a_accept_enters, clk, arst_n, (mix_valid && !mix_stall) |=> v_s1, "An accepted request did not enter the first stage.")
	`ASSERT_PROP(a_stall_holds, clk, arst_n, (v_s4 && res_stall && v_s3) |=> (v_s3 && $stable(idx_s3)), "A stalled pipeline moved its third stage.")
	`ASSERT_NEVER(a_gain_clamped, clk, arst_n, gain_q > UNITY_GAIN, "The gain register holds more than unity.")
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench of the saturating gain mixer: directed, random and stall-fill requests.
module tb_top
	import sgm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;
	localparam int PERIOD_CHUNK = 150;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		logic               act;
		logic [POS_W-1:0]   base;
		logic [POS_W-1:0]   off;
		logic [EXT_W-1:0]   ext;
		logic [DATA_W-1:0]  smp;
	} mix_req_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   mix_valid = 1'b0;
	logic                   mix_stall;
	logic                   action = ACT_MIX;
	logic [POS_W-1:0]       ring_base = '0;
	logic [POS_W-1:0]       offset = '0;
	logic [EXT_W-1:0]       mixed_extent = '0;
	logic signed [DATA_W-1:0] sample = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	logic signed [DATA_W-1:0] stored_value;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic [DATA_W-1:0] ring_copy [RING_DEPTH_DEF];
	bit                slot_written [RING_DEPTH_DEF];
	logic [FMT_W-1:0]  fmt_cfg = FMT_S32;
	logic [GAIN_W-1:0] gain_cfg = UNITY_GAIN;
	logic [DATA_W-1:0] expected_values [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int requests_sent = 0;
	int reads_sent = 0;
	int accum_mixes = 0;
	int config_writes = 0;
	int mismatch_count = 0;

	saturating_gain_mixer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.mix_valid    (mix_valid),
		.mix_stall    (mix_stall),
		.action       (action),
		.ring_base    (ring_base),
		.offset       (offset),
		.mixed_extent (mixed_extent),
		.sample       (sample),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.stored_value (stored_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	function automatic longint sign_low(logic [DATA_W-1:0] x, int unsigned nbits);
		longint v;
		v = {32'd0, x};
		v = v << (64 - nbits);
		return v >>> (64 - nbits);
	endfunction

	function automatic logic [DATA_W-1:0] apply_mix(mix_req_t r);
		logic [POS_W-1:0] slot;
		int unsigned nbits;
		longint src;
		longint scaled;
		longint acc;
		longint hi;
		longint lo;
		slot = r.base + r.off;
		if (r.act == ACT_READ) begin
			return ring_copy[slot];
		end
		nbits = (fmt_cfg == FMT_S16) ? 16 : (fmt_cfg == FMT_S24) ? 24 : 32;
		src = sign_low(r.smp, nbits);
		scaled = ((src * longint'(gain_cfg)) >>> (GAIN_SHIFT - 1)) + 1;
		scaled = scaled >>> 1;
		if (r.off < r.ext) begin
			acc = sign_low(ring_copy[slot], nbits) + scaled;
			accum_mixes++;
		end else begin
			acc = scaled;
		end
		hi = (longint'(1) << (nbits - 1)) - 1;
		lo = -hi - 1;
		if (acc > hi) begin
			acc = hi;
		end else if (acc < lo) begin
			acc = lo;
		end
		ring_copy[slot] = acc[DATA_W-1:0];
		slot_written[slot] = 1'b1;
		return ring_copy[slot];
	endfunction

	function automatic mix_req_t make_req(int act, int base, int off, int ext,
		logic [DATA_W-1:0] smp);
		mix_req_t r;
		r.act = 1'(act);
		r.base = POS_W'(base);
		r.off = POS_W'(off);
		r.ext = EXT_W'(ext);
		r.smp = smp;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_sample();
		logic [DATA_W-1:0] s;
		s = $urandom;
		case ($urandom_range(5))
			0: s[15:0] = s[31] ? 16'h8000 + s[3:0] : 16'h7FFF - s[3:0];
			1: s[23:0] = s[31] ? 24'h800000 + s[3:0] : 24'h7FFFFF - s[3:0];
			2: s = s[30] ? 32'h8000_0000 + s[3:0] : 32'h7FFF_FFFF - s[3:0];
			3: s = {{22{s[31]}}, s[9:0]};
			default: ;
		endcase
		return s;
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FORMAT) begin
			fmt_cfg = data[FMT_W-1:0];
		end else begin
			gain_cfg = (data > UNITY_GAIN) ? UNITY_GAIN : data;
		end
		cfg_valid <= 1'b0;
		config_writes++;
		@(posedge clk);
	endtask

	task automatic send_item(input mix_req_t req);
		logic [POS_W-1:0] slot;
		slot = req.base + req.off;
		// Slots that were never written must not be read or mixed into.
		if (!slot_written[slot]) begin
			if (req.act == ACT_READ) begin
				req.act = ACT_MIX;
			end
			if (req.off < req.ext) begin
				req.ext = EXT_W'(req.off);
			end
		end
		while ($urandom_range(99) < send_idle_pct) begin
			mix_valid <= 1'b0;
			@(posedge clk);
		end
		mix_valid <= 1'b1;
		action <= req.act;
		ring_base <= req.base;
		offset <= req.off;
		mixed_extent <= req.ext;
		sample <= req.smp;
		do @(posedge clk); while (mix_stall);
		expected_values.push_back(apply_mix(req));
		requests_sent++;
		if (req.act == ACT_READ) begin
			reads_sent++;
		end
	endtask

	task automatic wait_idle();
		mix_valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic pick_config();
		logic [CFG_DATA_W-1:0] g;
		case ($urandom_range(5))
			0: g = '0;
			1: g = UNITY_GAIN;
			2: g = '1;
			3: g = CFG_DATA_W'(1);
			default: g = CFG_DATA_W'($urandom_range(2047));
		endcase
		write_register(CFG_FORMAT, CFG_DATA_W'($urandom_range(2047)));
		write_register(CFG_GAIN, g);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(CFG_FORMAT, CFG_DATA_W'(FMT_S32));
		write_register(CFG_GAIN, UNITY_GAIN);
		send_item(make_req(ACT_MIX, 0, 0, 0, 32'h7FFF_FFFF));
		send_item(make_req(ACT_MIX, 0, 0, 1, 32'h0000_0001));
		send_item(make_req(ACT_READ, 0, 0, 2047, 32'hFFFF_FFFF));
		send_item(make_req(ACT_MIX, 1023, 1023, 1023, 32'h8000_0000));
		send_item(make_req(ACT_MIX, 1023, 1023, 2047, 32'hFFFF_FFFF));
		send_item(make_req(ACT_READ, 1022, 0, 0, 32'h0));
		send_item(make_req(ACT_MIX, 512, 1, 0, 32'h1234_5678));
		wait_idle();
		write_register(CFG_FORMAT, CFG_DATA_W'(FMT_S16));
		write_register(CFG_GAIN, CFG_DATA_W'(512));
		send_item(make_req(ACT_MIX, 10, 0, 0, 32'h0001_8000));
		send_item(make_req(ACT_MIX, 10, 0, 1, 32'h0000_8000));
		send_item(make_req(ACT_MIX, 10, 0, 1, 32'h0000_8000));
		send_item(make_req(ACT_MIX, 11, 0, 0, 32'h0000_0003));
		send_item(make_req(ACT_MIX, 11, 0, 0, 32'hFFFF_FFFD));
		wait_idle();
		write_register(CFG_FORMAT, CFG_DATA_W'(FMT_SPARE));
		write_register(CFG_GAIN, '1);
		send_item(make_req(ACT_MIX, 20, 0, 0, 32'h8000_0000));
		send_item(make_req(ACT_READ, 20, 0, 1024, 32'h5555_AAAA));
		wait_idle();
		write_register(CFG_FORMAT, CFG_DATA_W'(FMT_S24));
		write_register(CFG_GAIN, '0);
		send_item(make_req(ACT_MIX, 30, 0, 0, 32'h007F_FFFF));
		wait_idle();
		write_register(CFG_GAIN, UNITY_GAIN);
		send_item(make_req(ACT_MIX, 30, 0, 0, 32'h007F_FFFF));
		send_item(make_req(ACT_MIX, 30, 0, 1, 32'h0000_0005));
		send_item(make_req(ACT_MIX, 31, 0, 0, 32'hA580_0000));
		send_item(make_req(ACT_MIX, 31, 0, 1, 32'h00FF_FFFF));
		send_item(make_req(ACT_READ, 31, 0, 0, 32'h0));
		send_item(make_req(ACT_READ, 0, 0, 0, 32'h0));
		wait_idle();
	endtask

	task automatic send_period();
		int base;
		int start;
		int len;
		int ext;
		int passes;
		base = $urandom_range(1023);
		start = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(63);
		len = $urandom_range(24, 1);
		case ($urandom_range(4))
			0: ext = 0;
			1: ext = start + len;
			2: ext = start + $urandom_range(len);
			3: ext = $urandom_range(1024);
			default: ext = $urandom_range(2047, 1024);
		endcase
		passes = $urandom_range(3, 1);
		for (int p = 0; p < passes; p++) begin
			for (int i = 0; i < len; i++) begin
				send_item(make_req(ACT_MIX, base, start + i, ext, pick_sample()));
			end
			ext = start + len;
		end
		if ($urandom_range(1) == 1) begin
			for (int i = 0; i < len; i++) begin
				send_item(make_req(ACT_READ, base, start + i, $urandom_range(2047), $urandom));
			end
		end
	endtask

	task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
		int target;
		int next_cfg;
		target = requests_sent + n_items;
		next_cfg = requests_sent;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (requests_sent < target) begin
			if (requests_sent >= next_cfg) begin
				wait_idle();
				pick_config();
				next_cfg = requests_sent + PERIOD_CHUNK;
			end
			if ($urandom_range(99) < 75) begin
				send_period();
			end else begin
				send_item(make_req($urandom_range(1), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(2047), $urandom));
			end
		end
		wait_idle();
	endtask

	task automatic test_full_pipeline_stall();
		int base;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		base = $urandom_range(1023);
		hold_request = 80;
		for (int i = 0; i < 40; i++) begin
			send_item(make_req(ACT_MIX, base, i % 8, i < 8 ? 0 : 8, pick_sample()));
		end
		for (int i = 0; i < 8; i++) begin
			send_item(make_req(ACT_READ, base, i, 0, 32'h0));
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		logic [DATA_W-1:0] want;
		if (res_valid && !res_stall) begin
			if (expected_values.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: unexpected result, expected none, actual %h", $time,
						stored_value);
				end
			end else begin
				want = expected_values.pop_front();
				if (stored_value !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: stored_value mismatch, expected %h, actual %h", $time,
							want, stored_value);
					end
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(620, 37, 62);
		test_random_traffic(620, 62, 37);
		test_full_pipeline_stall();
		test_random_traffic(590, 0, 0);
		$display("Checked %0d requests: %0d reads, %0d accumulating mixes, %0d register writes.",
			requests_sent, reads_sent, accum_mixes, config_writes);
		$display("All formats and gains from zero past unity, with stalls on both sides.");
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+hdl
hdl/sgm_pkg.sv
hdl/sgm_ring.sv
hdl/saturating_gain_mixer.sv
bench/tb_top.sv
